// ----- rtl/core/bfr_pkg.sv -----
`default_nettype none
package bfr_pkg;

  localparam int DEF_BUFFER_DEPTH   = 4096;
  localparam int DEF_MAX_FIELD_BITS = 32;
  localparam int CMD_QUEUE_DEPTH    = 2;
  localparam int RES_QUEUE_DEPTH    = 2;

  localparam logic [2:0] CMD_LOAD        = 3'd0;
  localparam logic [2:0] CMD_READ_U      = 3'd1;
  localparam logic [2:0] CMD_READ_S      = 3'd2;
  localparam logic [2:0] CMD_READ_OFFSET = 3'd3;
  localparam logic [2:0] CMD_PEEK        = 3'd4;
  localparam logic [2:0] CMD_ALIGN       = 3'd5;
  localparam logic [2:0] CMD_SEEK        = 3'd6;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  bit_count;
    logic        bias;
    logic [7:0]  align_multiple;
    logic [15:0] new_position;
    logic [11:0] load_index;
    logic [7:0]  load_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] field_value;
    logic [15:0]        bit_position;
    logic [15:0]        bits_remaining;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_READ,
    OP_PEEK,
    OP_ALIGN,
    OP_SEEK
  } op_t;

  typedef enum logic [1:0] {
    MODE_UNSIGNED,
    MODE_SIGNED,
    MODE_OFFSET
  } mode_t;

  // decoded command handed from front to back
  typedef struct packed {
    op_t         op;
    mode_t       mode;
    logic [5:0]  n;
    logic        bias;
    logic [7:0]  mult;
    logic [15:0] newp;
    logic        load_ok;
    logic [11:0] load_index;
    logic [7:0]  load_byte;
  } dec_t;

endpackage
`default_nettype wire

// ----- rtl/core/bfr_ram.sv -----
`default_nettype none
module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/core/bfr_fifo.sv -----
`default_nettype none
module bfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/bfr_front.sv -----
`default_nettype none
module bfr_front #(
  parameter int BUFFER_DEPTH   = bfr_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_FIELD_BITS = bfr_pkg::DEF_MAX_FIELD_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire bfr_pkg::in_item_t in_item,
  output logic                   in_full,
  output logic                   cmd_valid,
  output bfr_pkg::dec_t          cmd_item,
  input  wire logic              cmd_pop
);

  bfr_pkg::dec_t              dec;
  logic [$bits(bfr_pkg::dec_t)-1:0] q_rdata;
  logic                       q_empty;

  always_comb begin
    dec.op         = bfr_pkg::OP_NOP;
    dec.mode       = bfr_pkg::MODE_UNSIGNED;
    dec.n          = (in_item.bit_count > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS)
                                                              : in_item.bit_count;
    dec.bias       = in_item.bias;
    dec.mult       = in_item.align_multiple;
    dec.newp       = in_item.new_position;
    dec.load_ok    = (32'(in_item.load_index) < 32'(BUFFER_DEPTH));
    dec.load_index = in_item.load_index;
    dec.load_byte  = in_item.load_byte;
    case (in_item.cmd)
      bfr_pkg::CMD_LOAD:        dec.op = bfr_pkg::OP_LOAD;
      bfr_pkg::CMD_READ_U:      dec.op = bfr_pkg::OP_READ;
      bfr_pkg::CMD_READ_S: begin
        dec.op   = bfr_pkg::OP_READ;
        dec.mode = bfr_pkg::MODE_SIGNED;
      end
      bfr_pkg::CMD_READ_OFFSET: begin
        dec.op   = bfr_pkg::OP_READ;
        dec.mode = bfr_pkg::MODE_OFFSET;
      end
      bfr_pkg::CMD_PEEK:        dec.op = bfr_pkg::OP_PEEK;
      bfr_pkg::CMD_ALIGN:       dec.op = bfr_pkg::OP_ALIGN;
      bfr_pkg::CMD_SEEK:        dec.op = bfr_pkg::OP_SEEK;
      default:                  dec.op = bfr_pkg::OP_NOP;
    endcase
  end

  bfr_fifo #(
    .WIDTH ($bits(bfr_pkg::dec_t)),
    .DEPTH (bfr_pkg::CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (dec),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign cmd_valid = ~q_empty;
  assign cmd_item  = bfr_pkg::dec_t'(q_rdata);

endmodule
`default_nettype wire

// ----- rtl/core/bfr_back.sv -----
`default_nettype none
module bfr_back #(
  parameter int BUFFER_DEPTH   = bfr_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_FIELD_BITS = bfr_pkg::DEF_MAX_FIELD_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [12:0]   cfg_data,
  input  wire logic          cmd_valid,
  input  wire bfr_pkg::dec_t cmd_item,
  output logic               cmd_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output bfr_pkg::out_item_t res_item
);

  // bytes spanned by a full-width field at any bit offset
  localparam int NB  = (MAX_FIELD_BITS + 14) / 8;
  localparam int W   = NB * 8;
  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int KW  = $clog2(NB + 1);
  // a 13-bit length never reaches a larger depth
  localparam int LEN_CAP = (BUFFER_DEPTH > 8191) ? 8191 : BUFFER_DEPTH;
  localparam logic [16:0] DEPTH17 = 17'(LEN_CAP);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_FETCH   = 8'b0000_0010,
    S_DRAIN   = 8'b0000_0100,
    S_EXTRACT = 8'b0000_1000,
    S_FORM    = 8'b0001_0000,
    S_DIV     = 8'b0010_0000,
    S_ALIGN   = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t                    state_r, state_nxt;
  bfr_pkg::dec_t             cur_r, cur_nxt;
  logic [15:0]               pos_r, pos_nxt;
  logic [12:0]               bb_r, bb_nxt;
  logic [KW-1:0]             k_r, k_nxt;
  logic [W-1:0]              win_r, win_nxt;
  logic [MAX_FIELD_BITS-1:0] raw_r, raw_nxt;
  logic [31:0]               field_r, field_nxt;
  logic [16:0]               p_r, p_nxt;
  logic [16:0]               dp_r, dp_nxt;
  logic [7:0]                rem_r, rem_nxt;
  logic [4:0]                cnt_r, cnt_nxt;

  logic [16:0]               len17, pos17, avail17, lidx17, rd_sum, aligned;
  logic [15:0]               base;
  logic [5:0]                take;
  logic [W-1:0]              shifted;
  logic [MAX_FIELD_BITS-1:0] raw_calc;
  logic [31:0]               fu, sgn, off, field_calc;
  logic [8:0]                rem2;
  logic                      start;
  logic                      mem_we;
  logic [7:0]                rdata;

  function automatic logic [15:0] clamp(input logic [16:0] x, input logic [16:0] len);
    clamp = (x > len) ? len[15:0] : x[15:0];
  endfunction

  assign len17   = ((17'(bb_r) > DEPTH17) ? DEPTH17 : 17'(bb_r)) << 3;
  assign pos17   = 17'(pos_r);
  assign avail17 = (pos17 < len17) ? (len17 - pos17) : '0;
  assign start   = state_r[0] & cmd_valid & ~res_full;
  assign lidx17  = 17'(cmd_item.load_index);
  assign mem_we  = start & (cmd_item.op == bfr_pkg::OP_LOAD) & cmd_item.load_ok;
  assign base    = {3'b000, pos_r[15:3]} + 16'(k_r);

  bfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (lidx17[AW-1:0]),
    .wdata (cmd_item.load_byte),
    .raddr (base[AW-1:0]),
    .rdata (rdata)
  );

  // field extraction: funnel shift, then keep only bits that lie inside the buffer
  assign take     = (17'(cur_r.n) < avail17) ? cur_r.n : avail17[5:0];
  assign shifted  = win_r << pos_r[2:0];
  assign raw_calc = shifted[W-1 -: MAX_FIELD_BITS] & ~({MAX_FIELD_BITS{1'b1}} >> take);

  assign fu  = 32'(raw_r >> (6'(MAX_FIELD_BITS) - cur_r.n));
  assign sgn = fu >> (cur_r.n - 6'd1);
  assign off = (32'd1 << (cur_r.n - 6'd1)) - {31'b0, cur_r.bias};

  always_comb begin
    field_calc = fu;
    if (cur_r.n == '0) begin
      field_calc = '0;
    end else begin
      case (cur_r.mode)
        bfr_pkg::MODE_SIGNED: begin
          if (sgn[0]) begin
            field_calc = fu | (32'hffff_ffff << cur_r.n);
          end
        end
        bfr_pkg::MODE_OFFSET: field_calc = fu - off;
        default:              field_calc = fu;
      endcase
    end
  end

  assign rd_sum  = pos17 + 17'(cur_r.n);
  assign rem2    = {rem_r, dp_r[16]};
  assign aligned = p_r - 17'(rem_r);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    pos_nxt   = pos_r;
    bb_nxt    = bb_r;
    k_nxt     = k_r;
    win_nxt   = win_r;
    raw_nxt   = raw_r;
    field_nxt = field_r;
    p_nxt     = p_r;
    dp_nxt    = dp_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_pop   = 1'b1;
          cur_nxt   = cmd_item;
          field_nxt = '0;
          k_nxt     = '0;
          case (cmd_item.op)
            bfr_pkg::OP_READ,
            bfr_pkg::OP_PEEK: state_nxt = S_FETCH;
            bfr_pkg::OP_SEEK: begin
              pos_nxt   = clamp(17'(cmd_item.newp), len17);
              state_nxt = S_DONE;
            end
            bfr_pkg::OP_ALIGN: begin
              p_nxt     = pos17 + 17'(cmd_item.mult) - 17'd1;
              dp_nxt    = pos17 + 17'(cmd_item.mult) - 17'd1;
              rem_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = (cmd_item.mult == '0) ? S_DONE : S_DIV;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_FETCH: begin
        // registered read data arrives in the cycle after its address
        if (k_r != '0) begin
          win_nxt = {win_r[W-9:0], rdata};
        end
        k_nxt = k_r + 1'b1;
        if (k_r == KW'(NB - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        win_nxt   = {win_r[W-9:0], rdata};
        state_nxt = S_EXTRACT;
      end
      S_EXTRACT: begin
        raw_nxt   = raw_calc;
        state_nxt = S_FORM;
      end
      S_FORM: begin
        field_nxt = field_calc;
        if (cur_r.op == bfr_pkg::OP_READ) begin
          pos_nxt = clamp(rd_sum, len17);
        end
        state_nxt = S_DONE;
      end
      S_DIV: begin
        // restoring remainder, one dividend bit per cycle
        if (rem2 >= {1'b0, cur_r.mult}) begin
          rem_nxt = 8'(rem2 - {1'b0, cur_r.mult});
        end else begin
          rem_nxt = rem2[7:0];
        end
        dp_nxt  = {dp_r[15:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd16) begin
          state_nxt = S_ALIGN;
        end
      end
      S_ALIGN: begin
        pos_nxt   = clamp(aligned, len17);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_push  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we) begin
      bb_nxt  = cfg_data;
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      bb_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      bb_r    <= bb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    k_r     <= k_nxt;
    win_r   <= win_nxt;
    raw_r   <= raw_nxt;
    field_r <= field_nxt;
    p_r     <= p_nxt;
    dp_r    <= dp_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign res_item.field_value    = field_r;
  assign res_item.bit_position   = pos_r;
  assign res_item.bits_remaining = avail17[15:0];

endmodule
`default_nettype wire

// ----- rtl/core/msb_first_bit_field_reader_top.sv -----
// MSB-first bit field reader: bytes are loaded into an internal buffer with the load
// command and fields of 0 to MAX_FIELD_BITS bits are then read or peeked from a bit
// position, unsigned, sign-extended or offset-binary; align and seek move the position,
// which always saturates at the buffer end set by cfg_data (writing it zeroes the
// position). Items are accepted into a two-entry command queue and executed one at a
// time; results leave through a two-entry result queue. A read or peek fetches NB =
// (MAX_FIELD_BITS+14)/8 bytes (5 at 32 bits), one byte a cycle from the single read
// port of the byte store; an align derives its remainder in a bit-serial unit, and an
// align by zero skips it. The byte store has no reset; read only loaded bytes.
`default_nettype none
module msb_first_bit_field_reader_top #(
  parameter int BUFFER_DEPTH   = bfr_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_FIELD_BITS = bfr_pkg::DEF_MAX_FIELD_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire bfr_pkg::in_item_t  in_item,
  output logic                    in_full,
  input  wire logic               out_pop,
  output bfr_pkg::out_item_t      out_item,
  output logic                    out_empty,
  input  wire logic               cfg_we,
  input  wire logic [12:0]        cfg_data
);

  logic                            cmd_valid;
  bfr_pkg::dec_t                   cmd_item;
  logic                            cmd_pop;
  logic                            res_full;
  logic                            res_push;
  bfr_pkg::out_item_t              res_item;
  logic [$bits(bfr_pkg::out_item_t)-1:0] res_rdata;

  bfr_front #(
    .BUFFER_DEPTH   (BUFFER_DEPTH),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_pop   (cmd_pop)
  );

  bfr_back #(
    .BUFFER_DEPTH   (BUFFER_DEPTH),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  bfr_fifo #(
    .WIDTH ($bits(bfr_pkg::out_item_t)),
    .DEPTH (bfr_pkg::RES_QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_item = bfr_pkg::out_item_t'(res_rdata);

endmodule
`default_nettype wire

// ----- rtl/core/bfr_checker.sv -----
`default_nettype none
module bfr_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_push,
  input wire logic               in_full,
  input wire logic               out_pop,
  input wire bfr_pkg::out_item_t out_item,
  input wire logic               out_empty
);

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a waiting result beat holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("result beat changed while waiting");

  // the command queue only fills on an accepted beat
  a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
    !in_full && !in_push |=> !in_full)
    else $error("input full without a push");

  // position plus remaining bits is the buffer length, a whole number of bytes
  a_len_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> 3'(out_item.bit_position[2:0] + out_item.bits_remaining[2:0]) == 3'd0)
    else $error("position and remaining bits do not end on a byte");

endmodule

bind msb_first_bit_field_reader_top bfr_checker u_bfr_checker (.*);
`default_nettype wire

// ----- tb/sv/bfr_field_checker.sv -----
`timescale 1ns / 1ps
module bfr_field_checker
  import bfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic       in_full,
  input  wire in_item_t   in_item,
  input  wire logic       out_pop,
  input  wire logic       out_empty,
  input  wire out_item_t  out_item,
  input  wire logic       cfg_we,
  input  wire logic [12:0] cfg_data,
  output int              fail_count,
  output int              pending_results
);

  localparam int DEPTH    = DEF_BUFFER_DEPTH;
  localparam int MAX_BITS = DEF_MAX_FIELD_BITS;

  logic [7:0]  byte_copy [DEPTH];
  int unsigned cur_pos;
  logic [12:0] len_bytes;
  out_item_t   expected_q [$];
  out_item_t   want;

  function automatic int unsigned end_bit();
    int unsigned b;
    b = 32'(len_bytes);
    if (b > DEPTH) b = DEPTH;
    return b * 8;
  endfunction

  function automatic int unsigned saturate(int unsigned p);
    int unsigned lim;
    lim = end_bit();
    return (p > lim) ? lim : p;
  endfunction

  // msb-first field at the current position, zero filled past the end
  function automatic logic [31:0] fetch_field(int unsigned n);
    int unsigned lim, avail, take, p, i;
    logic [63:0] acc;
    lim = end_bit();
    acc = '0;
    if (n == 0 || cur_pos >= lim) return '0;
    avail = lim - cur_pos;
    take = (n < avail) ? n : avail;
    for (i = 0; i < take; i++) begin
      p = cur_pos + i;
      acc = {acc[62:0], byte_copy[p >> 3][7 - (p & 7)]};
    end
    acc = acc << (n - take);
    return acc[31:0];
  endfunction

  function automatic out_item_t apply_cmd(in_item_t it);
    out_item_t   r;
    int unsigned n, lim, p, m;
    logic [31:0] f;
    f = '0;
    n = 32'(it.bit_count);
    m = 32'(it.align_multiple);
    if (n > MAX_BITS) n = MAX_BITS;
    case (it.cmd)
      CMD_LOAD: byte_copy[it.load_index] = it.load_byte;
      CMD_READ_U, CMD_READ_S, CMD_READ_OFFSET, CMD_PEEK: begin
        f = fetch_field(n);
        if (n != 0) begin
          if (it.cmd == CMD_READ_S) begin
            if (n < 32 && f[n - 1]) f = f | ~((32'd1 << n) - 32'd1);
          end else if (it.cmd == CMD_READ_OFFSET) begin
            f = f - ((32'd1 << (n - 1)) - 32'(it.bias));
          end
        end
        if (it.cmd != CMD_PEEK) cur_pos = saturate(cur_pos + n);
      end
      CMD_ALIGN: begin
        if (m != 0) begin
          p = cur_pos + m - 1;
          p = (p / m) * m;
          cur_pos = saturate(p);
        end
      end
      CMD_SEEK: cur_pos = saturate(32'(it.new_position));
      default: ;
    endcase
    lim = end_bit();
    r.field_value    = f;
    r.bit_position   = cur_pos[15:0];
    r.bits_remaining = (cur_pos < lim) ? 16'(lim - cur_pos) : 16'd0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_pos = 0;
      len_bytes = '0;
      fail_count = 0;
      expected_q.delete();
      pending_results <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, got %p", $time, out_item);
        end else begin
          want = expected_q.pop_front();
          if (out_item.field_value !== want.field_value) begin
            fail_count++;
            $display("%0t: field_value expected %h, got %h", $time,
                     want.field_value, out_item.field_value);
          end
          if (out_item.bit_position !== want.bit_position) begin
            fail_count++;
            $display("%0t: bit_position expected %0d, got %0d", $time,
                     want.bit_position, out_item.bit_position);
          end
          if (out_item.bits_remaining !== want.bits_remaining) begin
            fail_count++;
            $display("%0t: bits_remaining expected %0d, got %0d", $time,
                     want.bits_remaining, out_item.bits_remaining);
          end
        end
      end
      // a length write also rewinds the position
      if (cfg_we) begin
        len_bytes = cfg_data;
        cur_pos = 0;
      end
      if (in_push && !in_full) expected_q.push_back(apply_cmd(in_item));
      pending_results <= expected_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_msb_first_bit_field_reader_top.sv -----
`timescale 1ns / 1ps
module tb_msb_first_bit_field_reader_top;
  import bfr_pkg::*;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 80;
  localparam int FILL_BYTES  = 256;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  in_item_t    in_item = '0;
  logic        out_pop = 1'b0;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_data = '0;
  wire         in_full;
  wire         out_empty;
  out_item_t   out_item;

  int   fail_count;
  int   pending_results;
  int   send_idle = 34;
  int   recv_idle = 71;
  logic hold_go = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  msb_first_bit_field_reader_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  bfr_field_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_item         (in_item),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // result side: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_go) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      out_pop <= !hold_go && (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_item_t make_cmd(logic [2:0] c, logic [5:0] n, logic b,
                                        logic [7:0] m, logic [15:0] np,
                                        logic [11:0] li, logic [7:0] lb);
    in_item_t it;
    it.cmd = c;
    it.bit_count = n;
    it.bias = b;
    it.align_multiple = m;
    it.new_position = np;
    it.load_index = li;
    it.load_byte = lb;
    return it;
  endfunction

  // seek inside the filled bytes, or to the end of the buffer
  function automatic in_item_t safe_seek();
    logic [15:0] np;
    if ($urandom_range(0, 99) < 90)
      np = 16'($urandom_range(0, FILL_BYTES * 8 - DEF_MAX_FIELD_BITS));
    else
      np = 16'hffff;
    return make_cmd(CMD_SEEK, 6'd0, 1'b0, 8'd0, np, 12'd0, 8'd0);
  endfunction

  function automatic in_item_t random_cmd(int unsigned len_b);
    in_item_t    it;
    int unsigned lim_bytes, r;
    lim_bytes = (len_b > DEF_BUFFER_DEPTH) ? DEF_BUFFER_DEPTH : len_b;
    r = $urandom_range(0, 99);
    if (r < 18) it.cmd = CMD_LOAD;
    else if (r < 38) it.cmd = CMD_READ_U;
    else if (r < 50) it.cmd = CMD_READ_S;
    else if (r < 62) it.cmd = CMD_READ_OFFSET;
    else if (r < 72) it.cmd = CMD_PEEK;
    else if (r < 81) it.cmd = CMD_ALIGN;
    else if (r < 95) it.cmd = CMD_SEEK;
    else it.cmd = CMD_UNUSED;
    if ($urandom_range(0, 99) < 85) it.bit_count = 6'($urandom_range(0, 32));
    else it.bit_count = 6'($urandom_range(33, 63));
    it.bias = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1) != 0) it.align_multiple = 8'($urandom_range(1, 16));
    else it.align_multiple = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 70) it.new_position = 16'($urandom_range(0, lim_bytes * 8));
    else it.new_position = 16'($urandom);
    if (lim_bytes != 0 && $urandom_range(0, 99) < 70)
      it.load_index = 12'($urandom_range(0, lim_bytes - 1));
    else
      it.load_index = 12'($urandom_range(0, DEF_BUFFER_DEPTH - 1));
    it.load_byte = 8'($urandom);
    return it;
  endfunction

  task automatic push_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
  endtask

  task automatic wait_results_done();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic write_length(logic [12:0] b);
    cfg_data <= b;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int mode, ph, k, i;
    logic [12:0] len_b;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty buffer, then a 4-byte buffer
    push_item(make_cmd(CMD_READ_U, 6'd8, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    wait_results_done();
    write_length(13'd4);
    push_item(make_cmd(CMD_LOAD, 6'd0, 1'b0, 8'd0, 16'd0, 12'd0, 8'ha5));
    push_item(make_cmd(CMD_LOAD, 6'd0, 1'b0, 8'd0, 16'd0, 12'd1, 8'h0f));
    push_item(make_cmd(CMD_LOAD, 6'd0, 1'b0, 8'd0, 16'd0, 12'd2, 8'h80));
    push_item(make_cmd(CMD_LOAD, 6'd0, 1'b0, 8'd0, 16'd0, 12'd3, 8'hff));
    push_item(make_cmd(CMD_LOAD, 6'd0, 1'b0, 8'd0, 16'd0, 12'hfff, 8'h5a));
    // zero counts in every read mode, then a full-width peek and 4-bit signed and offset reads
    push_item(make_cmd(CMD_READ_U, 6'd0, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_READ_S, 6'd0, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_READ_OFFSET, 6'd0, 1'b1, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_PEEK, 6'd32, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_READ_S, 6'd4, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_READ_OFFSET, 6'd4, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_READ_OFFSET, 6'd4, 1'b1, 8'd0, 16'd0, 12'd0, 8'd0));
    // oversized count running across the end, then a read at the end
    push_item(make_cmd(CMD_READ_U, 6'd63, 1'b1, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_READ_U, 6'd1, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_SEEK, 6'd0, 1'b0, 8'd0, 16'hffff, 12'd0, 8'd0));
    push_item(make_cmd(CMD_SEEK, 6'd0, 1'b0, 8'd0, 16'd3, 12'd0, 8'd0));
    push_item(make_cmd(CMD_ALIGN, 6'd0, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_ALIGN, 6'd0, 1'b0, 8'hff, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_SEEK, 6'd0, 1'b0, 8'd0, 16'd1, 12'd0, 8'd0));
    push_item(make_cmd(CMD_ALIGN, 6'd0, 1'b0, 8'd3, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_READ_S, 6'd32, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_SEEK, 6'd0, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_READ_S, 6'd32, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_SEEK, 6'd0, 1'b0, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_READ_OFFSET, 6'd32, 1'b1, 8'd0, 16'd0, 12'd0, 8'd0));
    push_item(make_cmd(CMD_UNUSED, 6'h3f, 1'b1, 8'hff, 16'hffff, 12'hfff, 8'hff));

    // fill the start of the store; longer buffers are only read right after a seek
    // into this part or at their end
    for (i = 0; i < FILL_BYTES; i++)
      push_item(make_cmd(CMD_LOAD, 6'd0, 1'b0, 8'd0, 16'd0, 12'(i), 8'($urandom)));

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle = 34; recv_idle = 71; end
        1: begin send_idle = 71; recv_idle = 34; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (ph = 0; ph < PHASES; ph++) begin
        k = mode * PHASES + ph;
        wait_results_done();
        case (k)
          0: len_b = 13'h1fff;
          1: len_b = 13'd0;
          2: len_b = 13'd4096;
          3: len_b = 13'd1;
          default: begin
            if ($urandom_range(0, 99) < 80) len_b = 13'($urandom_range(1, 48));
            else len_b = 13'($urandom_range(49, FILL_BYTES));
          end
        endcase
        write_length(len_b);
        // receiver holds off while the sender keeps going, so the input stalls
        if (k == 1 || k == 10) begin
          hold_go <= 1'b1;
          @(posedge clk);
          hold_go <= 1'b0;
        end
        for (i = 0; i < PHASE_ITEMS; i++) begin
          if (32'(len_b) > FILL_BYTES) push_item(safe_seek());
          push_item(random_cmd(32'(len_b)));
        end
      end
    end

    wait_results_done();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
